FILE: rtl/lfr_pkg.sv
// ---------------------------------------------------------------------------
// lfr_pkg
// shared types and constants of the lidar frame relay
// ---------------------------------------------------------------------------
package lfr_pkg;

   localparam int COUNT_W        = 7;
   localparam int DIST_FRAME_LEN = 10;
   localparam int POS_FRAME_LEN  = 6;
   localparam int STORE_DEPTH    = 8;
   localparam int STORE_AW       = $clog2(STORE_DEPTH);
   localparam int BEAT_W         = 4;
   localparam int CSR_IDX_W      = 4;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_DIST = 2'd1,
      KIND_POS  = 2'd2,
      KIND_OBST = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC      = 4'd0,
      CSR_TYPE_DIST = 4'd1,
      CSR_TYPE_POS  = 4'd2,
      CSR_TYPE_OBST = 4'd3
   } csr_index_type;

   localparam logic [7:0] SYNC_RESET      = 8'hAA;
   localparam logic [7:0] TYPE_DIST_RESET = 8'h55;
   localparam logic [7:0] TYPE_POS_RESET  = 8'h56;
   localparam logic [7:0] TYPE_OBST_RESET = 8'h57;

   localparam logic [7:0] HDR_FIRST   = 8'hAA;
   localparam logic [7:0] HDR_SECOND  = 8'h55;
   localparam logic [7:0] TRAILER     = 8'h5D;
   localparam logic [7:0] CMD_DIST_LO = 8'h06;
   localparam logic [7:0] CMD_DIST_HI = 8'h07;
   localparam logic [7:0] CMD_POS     = 8'h02;
   localparam logic [7:0] CMD_OBST    = 8'h08;

   localparam logic [BEAT_W-1:0] LAST_BEAT_DIST  = 4'd15;
   localparam logic [BEAT_W-1:0] LAST_BEAT_OTHER = 4'd7;

endpackage

FILE: rtl/lfr_channels.sv
// ---------------------------------------------------------------------------
// lfr channels
// valid/ready transaction channels of the lidar frame relay
// ---------------------------------------------------------------------------
interface lfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       run_last;

   modport source (output valid, output tx_byte, output run_last, input ready);
   modport sink   (input valid, input tx_byte, input run_last, output ready);
endinterface

FILE: rtl/lidar_frame_relay.sv
// ---------------------------------------------------------------------------
// lidar_frame_relay
// hunts sensor frames in a byte stream, buffers the body in a small ram
// and replays it as 8-byte command frames
// ---------------------------------------------------------------------------
//  channel   dir  payload             transaction
//  req_chan  in   rx_byte             valid && ready
//  rsp_chan  out  tx_byte, run_last   valid && ready
//  csr_*     in   index, wdata        csr_wr_en
//
//  one input transaction per cycle while ready is high; a trigger byte starts
//  8 or 16 output beats at one per cycle while the output does not stall,
//  set by the single read port of the body ram; body bytes and trigger bytes
//  wait while a replay is in progress; sync and type bytes are still taken
//  synchronous reset; no ram clearing pass
//  output stalls hold the beat register and pause the replay sequencer
// ---------------------------------------------------------------------------
module lidar_frame_relay (
   input  logic                          clock,
   input  logic                          reset,
   lfr_req_if.sink                       req_chan,
   lfr_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [lfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata
);
   import lfr_pkg::*;

   logic [7:0]          sync_ff, type_dist_ff, type_pos_ff, type_obst_ff;
   logic [COUNT_W-1:0]  count_ff;
   kind_type            kind_ff;
   logic                busy_ff;
   logic [BEAT_W-1:0]   pos_ff;
   kind_type            emit_kind_ff;
   logic                s1_valid_ff;
   logic [BEAT_W-1:0]   s1_pos_ff;
   kind_type            s1_kind_ff;
   logic [7:0]          store_mem [STORE_DEPTH];
   logic [7:0]          rd_data_ff;

   logic                req_fire;
   logic                in_body;
   logic [COUNT_W-1:0]  frame_len;
   logic [COUNT_W-1:0]  body_idx;
   logic                body_fill;
   logic                trigger;
   logic                mem_we;
   kind_type            type_kind;
   logic [BEAT_W-1:0]   last_pos;
   logic                issue;
   logic [STORE_AW-1:0] rd_addr;
   logic [1:0]          rd_off;
   logic [7:0]          cmd_byte;
   logic [BEAT_W-1:0]   s1_last_pos;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign in_body   = count_ff[COUNT_W-1:1] != '0;
   assign frame_len = (kind_ff == KIND_DIST) ? COUNT_W'(DIST_FRAME_LEN)
                                             : COUNT_W'(POS_FRAME_LEN);
   assign body_idx  = count_ff - COUNT_W'(2);
   assign body_fill = in_body && (kind_ff != KIND_NONE) && (count_ff < frame_len);
   assign trigger   = req_fire && in_body && (kind_ff != KIND_NONE) && !body_fill;
   assign mem_we    = req_fire && body_fill && (body_idx < COUNT_W'(STORE_DEPTH));

   assign req_chan.ready = !busy_ff || !in_body;

   always_comb begin
      if (req_chan.rx_byte == type_dist_ff) begin
         type_kind = KIND_DIST;
      end else if (req_chan.rx_byte == type_pos_ff) begin
         type_kind = KIND_POS;
      end else if (req_chan.rx_byte == type_obst_ff) begin
         type_kind = KIND_OBST;
      end else begin
         type_kind = KIND_NONE;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= SYNC_RESET;
         type_dist_ff <= TYPE_DIST_RESET;
         type_pos_ff  <= TYPE_POS_RESET;
         type_obst_ff <= TYPE_OBST_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SYNC:      sync_ff      <= csr_wdata;
            CSR_TYPE_DIST: type_dist_ff <= csr_wdata;
            CSR_TYPE_POS:  type_pos_ff  <= csr_wdata;
            CSR_TYPE_OBST: type_obst_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // frame parser
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         kind_ff  <= KIND_NONE;
      end else if (req_fire) begin
         if (count_ff == '0) begin
            if (req_chan.rx_byte == sync_ff) begin
               count_ff <= COUNT_W'(1);
            end
         end else if (count_ff == COUNT_W'(1)) begin
            kind_ff  <= type_kind;
            count_ff <= (type_kind != KIND_NONE) ? COUNT_W'(2) : '0;
         end else if (body_fill) begin
            count_ff <= count_ff + COUNT_W'(1);
         end else begin
            count_ff <= '0;
            kind_ff  <= KIND_NONE;
         end
      end
   end

   // body ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[body_idx[STORE_AW-1:0]] <= req_chan.rx_byte;
      end
   end

   assign rd_off  = pos_ff[1:0] - 2'd3;
   assign rd_addr = {pos_ff[3], rd_off};

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // replay sequencer
   assign last_pos = (emit_kind_ff == KIND_DIST) ? LAST_BEAT_DIST : LAST_BEAT_OTHER;
   assign issue    = busy_ff && (!s1_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         emit_kind_ff <= KIND_NONE;
      end else if (trigger) begin
         busy_ff      <= 1'b1;
         pos_ff       <= '0;
         emit_kind_ff <= kind_ff;
      end else if (issue) begin
         pos_ff <= pos_ff + BEAT_W'(1);
         if (pos_ff == last_pos) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || rsp_chan.ready) begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (!s1_valid_ff || rsp_chan.ready) begin
         s1_pos_ff  <= pos_ff;
         s1_kind_ff <= emit_kind_ff;
      end
   end

   always_comb begin
      case (s1_kind_ff)
         KIND_DIST: cmd_byte = s1_pos_ff[3] ? CMD_DIST_HI : CMD_DIST_LO;
         KIND_POS:  cmd_byte = CMD_POS;
         default:   cmd_byte = CMD_OBST;
      endcase
   end

   always_comb begin
      case (s1_pos_ff[2:0])
         3'd0:    rsp_chan.tx_byte = HDR_FIRST;
         3'd1:    rsp_chan.tx_byte = HDR_SECOND;
         3'd2:    rsp_chan.tx_byte = cmd_byte;
         3'd7:    rsp_chan.tx_byte = TRAILER;
         default: rsp_chan.tx_byte = rd_data_ff;
      endcase
   end

   assign s1_last_pos       = (s1_kind_ff == KIND_DIST) ? LAST_BEAT_DIST : LAST_BEAT_OTHER;
   assign rsp_chan.valid    = s1_valid_ff;
   assign rsp_chan.run_last = s1_pos_ff == s1_last_pos;

   // assertions
   body_write_not_during_replay: assert property (
      @(posedge clock) disable iff (reset) mem_we |-> !busy_ff
   ) else $error("body ram written during replay");

   trigger_only_when_idle: assert property (
      @(posedge clock) disable iff (reset) trigger |-> !busy_ff
   ) else $error("trigger transaction while sequencer busy");

   high_beats_only_for_distances: assert property (
      @(posedge clock) disable iff (reset)
         (busy_ff && pos_ff[3]) |-> (emit_kind_ff == KIND_DIST)
   ) else $error("second frame issued for a non-distance replay");

   replay_starts_after_trigger: assert property (
      @(posedge clock) disable iff (reset)
         trigger |=> (busy_ff && (pos_ff == '0))
   ) else $error("sequencer did not start after trigger");

endmodule

FILE: dv/lidar_frame_relay_test.sv
// ---------------------------------------------------------------------------
// lidar_frame_relay_test
// Self-checking testbench of the lidar frame relay. Byte streams of sensor
// frames, noise and broken headers go in on the request channel. The
// testbench predicts every outgoing command frame byte and checks it in
// order against the response channel. Both sides stall at random, and one
// long output hold-off backs the block up. Register settings change
// between phases.
// ---------------------------------------------------------------------------
module lidar_frame_relay_test;
   import lfr_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int IDLE_SETTLE     = 24;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       run_last;
   } relay_beat_type;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_wdata;

   lfr_req_if req_chan ();
   lfr_rsp_if rsp_chan ();

   lidar_frame_relay DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies and frame state
   logic [7:0]         sync_code;
   logic [7:0]         dist_code;
   logic [7:0]         pos_code;
   logic [7:0]         obst_code;
   logic [COUNT_W-1:0] rx_count;
   kind_type           rx_kind;
   logic [7:0]         body_ram [STORE_DEPTH];

   relay_beat_type  expected_beats[$];
   int              fail_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   bit              sender_gaps = 1'b1;
   bit              hold_pending = 1'b0;
   stall_style_type stall_style = STALL_NONE;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // frame prediction
   // ------------------------------------------------------------------
   function automatic void return_to_hunt();
      rx_count = '0;
      rx_kind  = KIND_NONE;
      for (int i = 0; i < STORE_DEPTH; i++) body_ram[i] = 8'h00;
   endfunction

   function automatic void push_cmd_frame(input logic [7:0] cmd, input int first,
                                          input bit last_frame);
      logic [7:0] frame [8];
      frame[0] = HDR_FIRST;
      frame[1] = HDR_SECOND;
      frame[2] = cmd;
      for (int i = 0; i < 4; i++) frame[3 + i] = body_ram[(first + i) % STORE_DEPTH];
      frame[7] = TRAILER;
      for (int i = 0; i < 8; i++)
         expected_beats.push_back(relay_beat_type'{tx_byte: frame[i],
                                                   run_last: last_frame && (i == 7)});
   endfunction

   function automatic void relay_step(input logic [7:0] b);
      int frame_len;
      int slot;
      if (rx_count == 0) begin
         if (b == sync_code) rx_count = COUNT_W'(1);
      end else if (rx_count == 1) begin
         if (b == dist_code) rx_kind = KIND_DIST;
         else if (b == pos_code) rx_kind = KIND_POS;
         else if (b == obst_code) rx_kind = KIND_OBST;
         else rx_kind = KIND_NONE;
         rx_count = (rx_kind != KIND_NONE) ? COUNT_W'(2) : COUNT_W'(0);
      end else if (rx_kind == KIND_NONE) begin
         return_to_hunt();
      end else begin
         frame_len = (rx_kind == KIND_DIST) ? DIST_FRAME_LEN : POS_FRAME_LEN;
         if (int'(rx_count) < frame_len) begin
            slot = int'(rx_count) - 2;
            if (slot < STORE_DEPTH) body_ram[slot] = b;
            rx_count = rx_count + 1'b1;
         end else begin
            case (rx_kind)
               KIND_DIST: begin
                  push_cmd_frame(CMD_DIST_LO, 0, 1'b0);
                  push_cmd_frame(CMD_DIST_HI, 4, 1'b1);
               end
               KIND_POS: push_cmd_frame(CMD_POS, 0, 1'b1);
               default:  push_cmd_frame(CMD_OBST, 0, 1'b1);
            endcase
            return_to_hunt();
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // monitor and checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      relay_beat_type want;
      if (reset) begin
         sync_code = SYNC_RESET;
         dist_code = TYPE_DIST_RESET;
         pos_code  = TYPE_POS_RESET;
         obst_code = TYPE_OBST_RESET;
         return_to_hunt();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SYNC:      sync_code = csr_wdata;
               CSR_TYPE_DIST: dist_code = csr_wdata;
               CSR_TYPE_POS:  pos_code  = csr_wdata;
               CSR_TYPE_OBST: obst_code = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) relay_step(req_chan.rx_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected response transaction: tx_byte %02h run_last %0b",
                      rsp_chan.tx_byte, rsp_chan.run_last);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_chan.tx_byte !== want.tx_byte) begin
                  $error("tx_byte mismatch: expected %02h, actual %02h",
                         want.tx_byte, rsp_chan.tx_byte);
                  fail_count++;
               end
               if (rsp_chan.run_last !== want.run_last) begin
                  $error("run_last mismatch: expected %0b, actual %0b",
                         want.run_last, rsp_chan.run_last);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("lidar_frame_relay regression: fail");
         $finish;
      end
   end

   // response side stalls
   initial begin
      int  run_left;
      bit  level;
      run_left = 0;
      level = 1'b1;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            case (stall_style)
               STALL_NONE:   rsp_chan.ready <= 1'b1;
               STALL_RANDOM: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default: begin
                  if (run_left == 0) begin
                     level = !level;
                     run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 6);
                  end
                  run_left--;
                  rsp_chan.ready <= level;
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic send_item(input logic [7:0] b);
      if (sender_gaps && burst_left == 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // writes all four registers plus one stray index that must be ignored
   task automatic load_settings(input logic [7:0] s, input logic [7:0] d,
                                input logic [7:0] p, input logic [7:0] o);
      wait_for_idle();
      csr_write(CSR_SYNC, s);
      csr_write(CSR_TYPE_DIST, d);
      csr_write(CSR_TYPE_POS, p);
      csr_write(CSR_TYPE_OBST, o);
      csr_write(CSR_IDX_W'(CSR_TYPE_OBST + $urandom_range(1, 12)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic send_frame(input kind_type kind, output int n_items);
      int body_len;
      body_len = ((kind == KIND_DIST) ? DIST_FRAME_LEN : POS_FRAME_LEN) - 2;
      send_item(sync_code);
      case (kind)
         KIND_DIST: send_item(dist_code);
         KIND_POS:  send_item(pos_code);
         default:   send_item(obst_code);
      endcase
      repeat (body_len) send_item(8'($urandom_range(0, 255)));
      send_item(8'($urandom_range(0, 255)));
      n_items = body_len + 3;
   endtask

   task automatic test_frame_kinds();
      int n;
      stall_style = STALL_NONE;
      send_frame(KIND_DIST, n);
      send_frame(KIND_POS, n);
      send_frame(KIND_OBST, n);
      wait_for_idle();
   endtask

   // an unmatched type byte is dropped and not taken as a new sync
   task automatic test_unmatched_type();
      logic [7:0] junk;
      do junk = 8'($urandom_range(0, 255));
      while (junk == dist_code || junk == pos_code || junk == obst_code);
      send_item(sync_code);
      send_item(junk);
      send_item(sync_code);
      send_item(sync_code);
      send_item(pos_code);
      wait_for_idle();
   endtask

   // distances win over position, position over obstacle; the kind is
   // latched at the type byte even if the codes change mid transaction
   task automatic test_overlapping_types();
      load_settings(8'h00, 8'hFF, 8'hFF, 8'hFF);
      send_item(8'h00);
      send_item(8'hFF);
      wait_for_idle();
      csr_write(CSR_TYPE_DIST, 8'h44);
      send_item(8'h00);
      send_item(8'hFF);
      repeat (DIST_FRAME_LEN - 4) send_item(8'($urandom_range(0, 255)));
      send_item(8'h80);
      wait_for_idle();
      send_item(8'h00);
      send_item(8'hFF);
      repeat (POS_FRAME_LEN - 2) send_item(8'($urandom_range(0, 255)));
      send_item(8'h7F);
      wait_for_idle();
   endtask

   task automatic test_output_backpressure();
      int n;
      wait_for_idle();
      sender_gaps = 1'b0;
      hold_pending = 1'b1;
      repeat (3) send_frame(KIND_DIST, n);
      sender_gaps = 1'b1;
      wait_for_idle();
   endtask

   task automatic test_random_traffic(input int item_goal);
      int         sent;
      int         n;
      int         pick;
      logic [7:0] junk;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            send_frame(kind_type'($urandom_range(1, 3)), n);
            sent += n;
         end else if (pick == 7) begin
            send_item(8'($urandom_range(0, 255)));
            sent += 1;
         end else if (pick == 8) begin
            do junk = 8'($urandom_range(0, 255));
            while (junk == dist_code || junk == pos_code || junk == obst_code);
            send_item(sync_code);
            send_item(junk);
            sent += 2;
         end else begin
            send_item(sync_code);
            send_item(8'($urandom_range(0, 255)));
            sent += 2;
         end
      end
      wait_for_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_SYNC;
      csr_wdata = 8'h00;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_frame_kinds();
      stall_style = STALL_RANDOM;
      test_unmatched_type();
      test_overlapping_types();

      load_settings(SYNC_RESET, TYPE_DIST_RESET, TYPE_POS_RESET, TYPE_OBST_RESET);
      stall_style = STALL_RUNS;
      test_random_traffic(55);

      load_settings(8'hFF, 8'h00, 8'h01, 8'hFE);
      stall_style = STALL_RANDOM;
      test_output_backpressure();
      test_random_traffic(55);

      load_settings(8'($urandom_range(0, 255)), 8'h3C, 8'hC3, 8'h81);
      stall_style = STALL_NONE;
      test_random_traffic(20);
      stall_style = STALL_RUNS;
      test_random_traffic(35);

      wait_for_idle();
      if (expected_beats.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("lidar_frame_relay regression: pass");
      end else begin
         $display("lidar_frame_relay regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lfr_pkg.sv
rtl/lfr_channels.sv
rtl/lidar_frame_relay.sv
dv/lidar_frame_relay_test.sv
